@@ hw/rtl/scdi_pkg.sv @@
// Shared constants, status codes and the detection result type for the de-interleaver.
`default_nettype none
package scdi_pkg;

  localparam int WORD_W            = 32;
  localparam int BLOCK_WORDS_DEF   = 16;
  localparam int STORE_DEPTH_DEF   = 32;
  localparam int MAX_PAIRS         = 8;
  // detection always settles by word 17, so the word index never passes 18
  localparam int MAX_DETECT_WORDS  = 18;
  localparam int SEEN_W            = 5;
  localparam int START_W           = 4;
  localparam int STATUS_W          = 2;
  localparam int COUNTER_WRAP_STEP = 15;
  localparam int LAST_CHECK_DIST   = 16;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 4;

  localparam logic [CFG_IDX_W-1:0] REG_AUTO_DETECT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COUNTER_LANE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_START_OFFSET = 2'd2;

  localparam logic [STATUS_W-1:0] STAT_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_NO_LANE  = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_NO_START = 2'd2;
  localparam logic [STATUS_W-1:0] STAT_SHORT    = 2'd3;

  typedef struct packed {
    logic                decided;
    logic                failed;
    logic [STATUS_W-1:0] status;
    logic                lane;
    logic [START_W-1:0]  start;
  } det_t;

endpackage
`default_nettype wire

@@ hw/rtl/scdi_ifs.sv @@
// Valid/ready channel interfaces: capture words in, pairs out, register writes.
`default_nettype none
interface scdi_stream_if;
  logic                         valid;
  logic                         ready;
  logic [scdi_pkg::WORD_W-1:0]  stream_word;
  logic                         end_of_capture;

  modport source (output valid, output stream_word, output end_of_capture, input ready);
  modport sink   (input valid, input stream_word, input end_of_capture, output ready);
endinterface

interface scdi_result_if;
  logic                          valid;
  logic                          ready;
  logic [scdi_pkg::WORD_W-1:0]   counter_word;
  logic [scdi_pkg::WORD_W-1:0]   sample_word;
  logic                          jump_flag;
  logic                          block_end;
  logic [scdi_pkg::STATUS_W-1:0] status;

  modport source (output valid, output counter_word, output sample_word, output jump_flag,
                  output block_end, output status, input ready);
  modport sink   (input valid, input counter_word, input sample_word, input jump_flag,
                  input block_end, input status, output ready);
endinterface

interface scdi_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [scdi_pkg::CFG_IDX_W-1:0]  index;
  logic [scdi_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

@@ hw/rtl/scdi_store.sv @@
// Capture word store: one write port, two registered read ports.
`default_nettype none
module scdi_store #(
  parameter int DEPTH = scdi_pkg::STORE_DEPTH_DEF
) (
  input  logic                         clk,
  input  logic                         we,
  input  logic [$clog2(DEPTH)-1:0]     waddr,
  input  logic [scdi_pkg::WORD_W-1:0]  wdata,
  input  logic                         re,
  input  logic [$clog2(DEPTH)-1:0]     raddr_a,
  input  logic [$clog2(DEPTH)-1:0]     raddr_b,
  output logic [scdi_pkg::WORD_W-1:0]  rdata_a,
  output logic [scdi_pkg::WORD_W-1:0]  rdata_b
);
  import scdi_pkg::*;

  logic [WORD_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule
`default_nettype wire

@@ hw/rtl/scdi_detect.sv @@
// Counter lane and sub-packet start detection over the first capture words.
`default_nettype none
module scdi_detect (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          step,
  input  logic                          clear,
  input  logic [scdi_pkg::WORD_W-1:0]   word,
  input  logic [scdi_pkg::SEEN_W-1:0]   k,
  input  logic                          auto_detect,
  input  logic                          counter_lane,
  input  logic [scdi_pkg::START_W-1:0]  start_offset,
  output scdi_pkg::det_t                det
);
  import scdi_pkg::*;

  logic [WORD_W-1:0]  hist0;
  logic [WORD_W-1:0]  hist1;
  logic               eq_a;
  logic               eq_b;
  logic               lane_ok;
  logic               lane_sel;
  logic [1:0]         brk_found;
  logic [START_W-1:0] brk_start0;
  logic [START_W-1:0] brk_start1;

  logic               gen_eq;
  logic               wrap_eq;
  logic               par;
  logic [SEEN_W-1:0]  brk_pos;
  logic               hit;
  logic               lane0c;
  logic               lane1c;
  logic               lane_ok_c;
  logic               lane_c;
  logic               recorded;
  logic [START_W-1:0] rec_start;
  logic               exhausted;

  // hist1 holds word k-2; every break test compares it with the current word
  assign gen_eq  = (hist1 == word + WORD_W'(1));
  assign wrap_eq = (word == hist1 + WORD_W'(COUNTER_WRAP_STEP));
  assign par     = k[0];
  assign brk_pos = k - SEEN_W'(par);
  assign hit     = (k >= SEEN_W'(2)) && (brk_pos <= SEEN_W'(LAST_CHECK_DIST)) && !gen_eq;

  // lane 0 test uses words 0 and 2, captured when word 2 came in
  assign lane0c    = eq_a | eq_b;
  assign lane1c    = gen_eq | wrap_eq;
  assign lane_ok_c = (k == SEEN_W'(3)) ? (lane0c | lane1c) : lane_ok;
  assign lane_c    = (k == SEEN_W'(3)) ? !lane0c : lane_sel;
  assign recorded  = lane_c ? brk_found[1] : brk_found[0];
  assign rec_start = lane_c ? brk_start1 : brk_start0;
  assign exhausted = k >= SEEN_W'(LAST_CHECK_DIST) + SEEN_W'(lane_c);

  always_comb begin
    det = '0;
    if (auto_detect) begin
      if (k >= SEEN_W'(3)) begin
        if (!lane_ok_c) begin
          det.failed = 1'b1;
          det.status = STAT_NO_LANE;
        end else if (recorded || (hit && (par == lane_c))) begin
          det.decided = 1'b1;
          det.lane    = lane_c;
          det.start   = recorded ? rec_start : brk_pos[START_W-1:0];
        end else if (exhausted) begin
          det.failed = 1'b1;
          det.status = STAT_NO_START;
        end
      end
    end else if (k >= SEEN_W'(start_offset)) begin
      det.decided = 1'b1;
      det.lane    = counter_lane;
      det.start   = start_offset;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      hist1 <= hist0;
      hist0 <= word;
    end
  end

  // both lanes are tracked, keeping the first break found on each, since the lane is only known at word 3
  always_ff @(posedge clk) begin
    if (rst || clear) begin
      eq_a      <= 1'b0;
      eq_b      <= 1'b0;
      lane_ok   <= 1'b0;
      lane_sel  <= 1'b0;
      brk_found <= 2'b00;
    end else if (step) begin
      if (k == SEEN_W'(2)) begin
        eq_a <= gen_eq;
        eq_b <= wrap_eq;
      end
      if (k == SEEN_W'(3)) begin
        lane_ok  <= lane0c | lane1c;
        lane_sel <= !lane0c;
      end
      if (hit && !par && !brk_found[0]) begin
        brk_found[0] <= 1'b1;
        brk_start0   <= brk_pos[START_W-1:0];
      end
      if (hit && par && !brk_found[1]) begin
        brk_found[1] <= 1'b1;
        brk_start1   <= brk_pos[START_W-1:0];
      end
    end
  end

endmodule
`default_nettype wire

@@ hw/rtl/subpacket_counter_deinterleaver_unit.sv @@
// Top level: capture control, block sequencing from the word store, result register.
//
//  channel  role   handshake    word carries
//  stream   sink   valid/ready  stream_word, end_of_capture
//  result   source valid/ready  counter_word, sample_word, jump_flag, block_end, status
//  cfg      sink   valid/ready  index, data (ready tied high)
//
// One capture word per cycle while stream.ready is high. A word that completes a block
// holds stream.ready low while S_EMIT_RD issues the first read, then S_EMIT_LD takes one
// pair per cycle from the dual-read word store, longer while result.ready is low. An error
// result holds it low in S_RESULT. Synchronous reset; the store is not cleared and needs no sweep.
`default_nettype none
module subpacket_counter_deinterleaver_unit #(
  parameter int BLOCK_WORDS = scdi_pkg::BLOCK_WORDS_DEF,
  parameter int STORE_DEPTH = scdi_pkg::STORE_DEPTH_DEF
) (
  input  logic          clk,
  input  logic          rst,
  scdi_stream_if.sink   stream,
  scdi_result_if.source result,
  scdi_cfg_if.sink      cfg
);
  import scdi_pkg::*;

  localparam int ADDR_W    = $clog2(STORE_DEPTH);
  localparam int PAIRS     = (BLOCK_WORDS / 2 > MAX_PAIRS) ? MAX_PAIRS : BLOCK_WORDS / 2;
  localparam int PAIR_W    = $clog2(PAIRS);
  localparam int FILL_MAX  = (BLOCK_WORDS > MAX_DETECT_WORDS) ? BLOCK_WORDS : MAX_DETECT_WORDS;
  localparam int FILL_W    = $clog2(FILL_MAX + 1);
  localparam int OFF_C     = (BLOCK_WORDS - 2) % STORE_DEPTH;
  localparam int BASE_STEP = BLOCK_WORDS % STORE_DEPTH;

  localparam logic [1:0] S_IDLE    = 2'd0;
  localparam logic [1:0] S_EMIT_RD = 2'd1;
  localparam logic [1:0] S_EMIT_LD = 2'd2;
  localparam logic [1:0] S_RESULT  = 2'd3;

  localparam logic [1:0] PH_DETECT = 2'd0;
  localparam logic [1:0] PH_RUN    = 2'd1;
  localparam logic [1:0] PH_FAIL   = 2'd2;

  function automatic logic [ADDR_W-1:0] wrap_sum(input logic [ADDR_W:0] s);
    logic [ADDR_W:0] t;
    t = (s >= (ADDR_W+1)'(STORE_DEPTH)) ? s - (ADDR_W+1)'(STORE_DEPTH) : s;
    return t[ADDR_W-1:0];
  endfunction

  function automatic logic [ADDR_W-1:0] step_back(input logic [ADDR_W-1:0] p);
    return (p < ADDR_W'(2)) ? p + ADDR_W'(STORE_DEPTH - 2) : p - ADDR_W'(2);
  endfunction

  // configuration registers
  logic                 auto_detect;
  logic                 counter_lane;
  logic [START_W-1:0]   start_offset;

  // control and capture state
  logic [1:0]           state;
  logic [1:0]           phase;
  logic [SEEN_W-1:0]    words_seen;
  logic                 found_lane;
  logic [START_W-1:0]   found_start;
  logic [FILL_W-1:0]    block_fill;
  logic [WORD_W-1:0]    previous_counter;
  logic                 have_previous;
  logic [ADDR_W-1:0]    wr_ptr;
  logic [ADDR_W-1:0]    blk_base;
  logic [ADDR_W-1:0]    cptr;
  logic [ADDR_W-1:0]    sptr;
  logic [PAIR_W-1:0]    pair_idx;
  logic                 clear_pending;
  logic [STATUS_W-1:0]  res_code;
  logic                 out_valid;

  logic                 in_acc;
  logic                 last;
  logic [SEEN_W-1:0]    k_next;
  det_t                 det;
  logic [FILL_W-1:0]    det_fill;
  logic [FILL_W-1:0]    run_fill;
  logic [FILL_W-1:0]    fill_base;
  logic [FILL_W-1:0]    fill_after;
  logic                 emit_now;
  logic                 fail_now;
  logic                 short_now;
  logic [1:0]           phase_after;
  logic                 slot_free;
  logic                 last_pair;
  logic                 cap_clear;

  logic                 we;
  logic [ADDR_W-1:0]    waddr;
  logic                 re;
  logic [ADDR_W-1:0]    raddr_c;
  logic [ADDR_W-1:0]    raddr_s;
  logic [ADDR_W-1:0]    init_c;
  logic [ADDR_W-1:0]    init_s;
  logic [WORD_W-1:0]    rdata_c;
  logic [WORD_W-1:0]    rdata_s;

  assign stream.ready = (state == S_IDLE);
  assign cfg.ready    = 1'b1;
  assign result.valid = out_valid;

  assign in_acc    = stream.valid && stream.ready;
  assign last      = stream.end_of_capture;
  assign k_next    = words_seen + SEEN_W'(1);
  assign slot_free = !out_valid || result.ready;
  assign last_pair = (pair_idx == PAIR_W'(PAIRS - 1));

  scdi_detect u_detect (
    .clk          (clk),
    .rst          (rst),
    .step         (in_acc && (phase == PH_DETECT)),
    .clear        (cap_clear),
    .word         (stream.stream_word),
    .k            (words_seen),
    .auto_detect  (auto_detect),
    .counter_lane (counter_lane),
    .start_offset (start_offset),
    .det          (det)
  );

  always_comb begin
    det_fill  = FILL_W'(k_next) - FILL_W'(det.start);
    run_fill  = block_fill + FILL_W'(1);
    fill_base = (phase == PH_DETECT) ? det_fill : run_fill;
    emit_now  = ((phase == PH_DETECT) && det.decided && (det_fill >= FILL_W'(BLOCK_WORDS))) ||
                ((phase == PH_RUN) && (run_fill >= FILL_W'(BLOCK_WORDS)));
    fill_after = emit_now ? fill_base - FILL_W'(BLOCK_WORDS) : fill_base;
    fail_now   = (phase == PH_DETECT) && det.failed;
    case (phase)
      PH_DETECT: phase_after = det.decided ? PH_RUN : (det.failed ? PH_FAIL : PH_DETECT);
      PH_RUN:    phase_after = PH_RUN;
      default:   phase_after = PH_FAIL;
    endcase
    short_now = last && !emit_now && !fail_now &&
                ((phase_after == PH_DETECT) || ((phase_after == PH_RUN) && !have_previous));
    cap_clear = ((state == S_IDLE) && in_acc && last && !emit_now) ||
                ((state == S_EMIT_LD) && slot_free && last_pair && clear_pending);
  end

  // store access: capture words go in as accepted unless detection failed; block pairs come out newest first
  assign we     = in_acc && (phase != PH_FAIL);
  assign waddr  = (phase == PH_DETECT) ? ADDR_W'(words_seen) : wr_ptr;
  assign init_c = wrap_sum({1'b0, blk_base} + (ADDR_W+1)'(OFF_C) + (ADDR_W+1)'(found_lane));
  assign init_s = wrap_sum({1'b0, blk_base} + (ADDR_W+1)'(OFF_C) + (ADDR_W+1)'(!found_lane));

  always_comb begin
    re      = 1'b0;
    raddr_c = cptr;
    raddr_s = sptr;
    case (state)
      S_EMIT_RD: begin
        re      = 1'b1;
        raddr_c = init_c;
        raddr_s = init_s;
      end
      S_EMIT_LD: begin
        re = slot_free && !last_pair;
      end
      default: begin
        re = 1'b0;
      end
    endcase
  end

  scdi_store #(
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk     (clk),
    .we      (we),
    .waddr   (waddr),
    .wdata   (stream.stream_word),
    .re      (re),
    .raddr_a (raddr_c),
    .raddr_b (raddr_s),
    .rdata_a (rdata_c),
    .rdata_b (rdata_s)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      auto_detect      <= 1'b1;
      counter_lane     <= 1'b0;
      start_offset     <= '0;
      state            <= S_IDLE;
      phase            <= PH_DETECT;
      words_seen       <= '0;
      found_lane       <= 1'b0;
      found_start      <= '0;
      block_fill       <= '0;
      previous_counter <= '0;
      have_previous    <= 1'b0;
      wr_ptr           <= '0;
      blk_base         <= '0;
      pair_idx         <= '0;
      clear_pending    <= 1'b0;
      out_valid        <= 1'b0;
    end else begin
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          REG_AUTO_DETECT:  auto_detect  <= cfg.data[0];
          REG_COUNTER_LANE: counter_lane <= cfg.data[0];
          REG_START_OFFSET: start_offset <= cfg.data[START_W-1:0];
          default: ;
        endcase
      end

      if (result.ready) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (in_acc) begin
            phase <= phase_after;
            if (phase == PH_DETECT) begin
              words_seen <= k_next;
              if (det.decided) begin
                found_lane  <= det.lane;
                found_start <= det.start;
                blk_base    <= ADDR_W'(det.start);
                wr_ptr      <= ADDR_W'(k_next);
                block_fill  <= fill_after;
              end
            end else if (phase == PH_RUN) begin
              wr_ptr     <= (wr_ptr == ADDR_W'(STORE_DEPTH - 1)) ? '0 : wr_ptr + ADDR_W'(1);
              block_fill <= fill_after;
            end
            if (emit_now) begin
              state         <= S_EMIT_RD;
              pair_idx      <= '0;
              clear_pending <= last;
            end else if (fail_now || short_now) begin
              state    <= S_RESULT;
              res_code <= fail_now ? det.status : STAT_SHORT;
            end
          end
        end
        S_EMIT_RD: begin
          cptr     <= step_back(init_c);
          sptr     <= step_back(init_s);
          blk_base <= wrap_sum({1'b0, blk_base} + (ADDR_W+1)'(BASE_STEP));
          state    <= S_EMIT_LD;
        end
        S_EMIT_LD: begin
          if (slot_free) begin
            out_valid           <= 1'b1;
            result.counter_word <= rdata_c;
            result.sample_word  <= rdata_s;
            result.jump_flag    <= have_previous && (rdata_c != previous_counter + WORD_W'(1));
            result.block_end    <= last_pair;
            result.status       <= STAT_OK;
            previous_counter    <= rdata_c;
            have_previous       <= 1'b1;
            if (last_pair) begin
              state         <= S_IDLE;
              clear_pending <= 1'b0;
            end else begin
              pair_idx <= pair_idx + PAIR_W'(1);
              cptr     <= step_back(cptr);
              sptr     <= step_back(sptr);
            end
          end
        end
        S_RESULT: begin
          if (slot_free) begin
            out_valid           <= 1'b1;
            result.counter_word <= '0;
            result.sample_word  <= '0;
            result.jump_flag    <= 1'b0;
            result.block_end    <= 1'b0;
            result.status       <= res_code;
            state               <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase

      // end of capture: back to a fresh capture, registers untouched
      if (cap_clear) begin
        phase            <= PH_DETECT;
        words_seen       <= '0;
        found_lane       <= 1'b0;
        found_start      <= '0;
        block_fill       <= '0;
        previous_counter <= '0;
        have_previous    <= 1'b0;
        wr_ptr           <= '0;
        blk_base         <= '0;
      end
    end
  end

endmodule
`default_nettype wire

@@ hw/rtl/scdi_checker.sv @@
// Port-level assertions for the de-interleaver and their bind to the top level.
`default_nettype none
module scdi_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [scdi_pkg::WORD_W-1:0]   counter_word,
  input logic [scdi_pkg::WORD_W-1:0]   sample_word,
  input logic                          jump_flag,
  input logic                          block_end,
  input logic [scdi_pkg::STATUS_W-1:0] status
);
  import scdi_pkg::*;

  // a stalled result word holds still
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(counter_word) && $stable(sample_word) &&
      $stable(jump_flag) && $stable(block_end) && $stable(status))
    else $error("result word changed while stalled");

  // error words carry nothing but the status
  a_err_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status != STAT_OK) |-> (counter_word == '0) && (sample_word == '0) &&
      !jump_flag && !block_end)
    else $error("error result with payload bits set");

  // while a block is still being drained, no capture word is taken
  a_drain_stall: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == STAT_OK) && !block_end |-> !in_ready)
    else $error("capture word accepted in the middle of a block");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind subpacket_counter_deinterleaver_unit scdi_checker u_scdi_checker (
  .clk          (clk),
  .rst          (rst),
  .in_ready     (stream.ready),
  .out_valid    (result.valid),
  .out_ready    (result.ready),
  .counter_word (result.counter_word),
  .sample_word  (result.sample_word),
  .jump_flag    (result.jump_flag),
  .block_end    (result.block_end),
  .status       (result.status)
);
`default_nettype wire
